// ----- hw/rtl/slwcg_pkg.sv -----
package slwcg_pkg;

   localparam logic [1:0] OP_SET_WINDOW   = 2'd0;
   localparam logic [1:0] OP_PUT_PIXEL    = 2'd1;
   localparam logic [1:0] OP_STREAM_PIXEL = 2'd2;
   localparam logic [1:0] OP_ROTATE       = 2'd3;

   localparam logic [1:0] ROT_0   = 2'd0;
   localparam logic [1:0] ROT_90  = 2'd1;
   localparam logic [1:0] ROT_180 = 2'd2;
   localparam logic [1:0] ROT_270 = 2'd3;

   localparam logic [7:0] CMD_CASET  = 8'h2A;
   localparam logic [7:0] CMD_RASET  = 8'h2B;
   localparam logic [7:0] CMD_RAMWR  = 8'h2C;
   localparam logic [7:0] CMD_MADCTL = 8'h36;

   localparam logic [7:0] MADCTL_ROT_0   = 8'h20;
   localparam logic [7:0] MADCTL_ROT_90  = 8'h40;
   localparam logic [7:0] MADCTL_ROT_180 = 8'hE0;
   localparam logic [7:0] MADCTL_ROT_270 = 8'h80;

   typedef struct packed {
      logic [1:0]  operation;
      logic [7:0]  x;
      logic [7:0]  y;
      logic [8:0]  width;
      logic [8:0]  height;
      logic [15:0] color;
      logic        end_of_burst;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       is_data;
      logic       group_end;
      logic       last;
   } rsp_type;

   // classified request as it waits in the queue
   typedef struct packed {
      logic [1:0]  op;
      logic [7:0]  row_start;
      logic [7:0]  row_end;
      logic [7:0]  col_start;
      logic [7:0]  col_end;
      logic [15:0] color;
      logic        end_of_burst;
      logic [7:0]  madctl;
   } job_type;

   function automatic logic [7:0] madctl_byte(input logic [1:0] rot);
      logic [7:0] result;
      case (rot)
         ROT_0:   result = MADCTL_ROT_0;
         ROT_90:  result = MADCTL_ROT_90;
         ROT_180: result = MADCTL_ROT_180;
         ROT_270: result = MADCTL_ROT_270;
         default: result = MADCTL_ROT_0;
      endcase
      return result;
   endfunction

endpackage

// ----- hw/rtl/spi_lcd_window_command_generator_unit.sv -----
// serial tft command generator
// request channel: drive req_data and raise start; the request is taken at a
// rising edge where start is high and busy is low. busy is high only while the
// request queue is full.
// response channel: one byte per cycle on rsp_data, marked by rsp_strobe for
// exactly one cycle; rsp_data.last flags the final byte of a request. the
// receiver cannot stall, so bytes leave as fast as the sequencer makes them.
// csr channel: csr_wdata sets the rotation; csr_ready is always high. rotation
// is sampled when a request is taken.
// path: a request goes through the queue, the job register and the output register.
// throughput: the byte sequencer emits one byte per cycle; a request makes 11 bytes
// (set window), 13 (put pixel) or 2 (stream pixel, rotation), and requests queued
// behind it follow with no gap.
// reset clears the queue, the sequencer and the rotation (0 degrees); no
// response is shown during reset.
module spi_lcd_window_command_generator_unit #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  slwcg_pkg::req_type req_data,
   output logic               rsp_strobe,
   output slwcg_pkg::rsp_type rsp_data,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_wdata
);

   logic               push;
   logic               pop;
   logic               queue_full;
   logic               queue_empty;
   slwcg_pkg::job_type front_job;
   slwcg_pkg::job_type queue_job;

   assign busy = queue_full;

   slwcg_front u_front (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .queue_full (queue_full),
      .req_data   (req_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata),
      .push       (push),
      .job        (front_job)
   );

   slwcg_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (push),
      .wr_data (front_job),
      .full    (queue_full),
      .rd_en   (pop),
      .rd_data (queue_job),
      .empty   (queue_empty)
   );

   slwcg_back u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_empty (queue_empty),
      .queue_data  (queue_job),
      .pop         (pop),
      .rsp_strobe  (rsp_strobe),
      .rsp_data    (rsp_data)
   );

endmodule

// ----- hw/rtl/slwcg_front.sv -----
module slwcg_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              queue_full,
   input  slwcg_pkg::req_type req_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_wdata,
   output logic              push,
   output slwcg_pkg::job_type job
);

   logic [1:0] rotation_ff;
   logic [1:0] rotation_in;
   logic       swap;
   logic [7:0] x_end;
   logic [7:0] y_end;

   assign csr_ready = 1'b1;

   always_comb begin
      rotation_in = rotation_ff;
      if (csr_valid && csr_ready) begin
         rotation_in = csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rotation_ff <= slwcg_pkg::ROT_0;
      end else begin
         rotation_ff <= rotation_in;
      end
   end

   assign push  = start && !queue_full;
   // odd rotations swap the window axes
   assign swap  = rotation_ff[0];
   assign x_end = 8'(req_data.x + req_data.width[7:0] - 8'd1);
   assign y_end = 8'(req_data.y + req_data.height[7:0] - 8'd1);

   always_comb begin
      job              = '0;
      job.op           = req_data.operation;
      job.color        = req_data.color;
      job.end_of_burst = req_data.end_of_burst;
      job.madctl       = slwcg_pkg::madctl_byte(rotation_ff);
      if (req_data.operation == slwcg_pkg::OP_PUT_PIXEL) begin
         // one-pixel window, x on the row axis when not swapped
         if (swap) begin
            job.row_start = req_data.y;
            job.row_end   = req_data.y;
            job.col_start = req_data.x;
            job.col_end   = req_data.x;
         end else begin
            job.row_start = req_data.x;
            job.row_end   = req_data.x;
            job.col_start = req_data.y;
            job.col_end   = req_data.y;
         end
      end else begin
         if (swap) begin
            job.row_start = req_data.x;
            job.row_end   = x_end;
            job.col_start = req_data.y;
            job.col_end   = y_end;
         end else begin
            job.row_start = req_data.y;
            job.row_end   = y_end;
            job.col_start = req_data.x;
            job.col_end   = x_end;
         end
      end
   end

endmodule

// ----- hw/rtl/slwcg_queue.sv -----
module slwcg_queue #(
   parameter int DEPTH = 2
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_en,
   input  slwcg_pkg::job_type wr_data,
   output logic              full,
   input  logic              rd_en,
   output slwcg_pkg::job_type rd_data,
   output logic              empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   slwcg_pkg::job_type mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff;
   logic [PTR_W-1:0]   wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff;
   logic [PTR_W-1:0]   rd_ptr_in;
   logic [CNT_W-1:0]   count_ff;
   logic [CNT_W-1:0]   count_in;
   logic               do_wr;
   logic               do_rd;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_wr   = wr_en && !full;
   assign do_rd   = rd_en && !empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

// ----- hw/rtl/slwcg_back.sv -----
module slwcg_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              queue_empty,
   input  slwcg_pkg::job_type queue_data,
   output logic              pop,
   output logic              rsp_strobe,
   output slwcg_pkg::rsp_type rsp_data
);

   localparam logic [3:0] S_ROW_CMD   = 4'd0;
   localparam logic [3:0] S_ROW_HI0   = 4'd1;
   localparam logic [3:0] S_ROW_START = 4'd2;
   localparam logic [3:0] S_ROW_HI1   = 4'd3;
   localparam logic [3:0] S_ROW_END   = 4'd4;
   localparam logic [3:0] S_COL_CMD   = 4'd5;
   localparam logic [3:0] S_COL_HI0   = 4'd6;
   localparam logic [3:0] S_COL_START = 4'd7;
   localparam logic [3:0] S_COL_HI1   = 4'd8;
   localparam logic [3:0] S_COL_END   = 4'd9;
   localparam logic [3:0] S_RAMWR     = 4'd10;
   localparam logic [3:0] S_COLOR_LO  = 4'd11;
   localparam logic [3:0] S_COLOR_HI  = 4'd12;
   localparam logic [3:0] S_FIRST     = 4'd0;

   logic               active_ff;
   logic               active_in;
   logic [3:0]         step_ff;
   logic [3:0]         step_in;
   slwcg_pkg::job_type job_ff;
   slwcg_pkg::job_type job_in;
   logic               strobe_ff;
   logic               strobe_in;
   slwcg_pkg::rsp_type rsp_ff;
   slwcg_pkg::rsp_type rsp_in;
   logic               done;

   // byte selection for the current step
   always_comb begin
      rsp_in = '0;
      case (job_ff.op)
         slwcg_pkg::OP_STREAM_PIXEL: begin
            rsp_in.is_data = 1'b1;
            if (step_ff == S_FIRST) begin
               rsp_in.out_byte = job_ff.color[7:0];
            end else begin
               rsp_in.out_byte  = job_ff.color[15:8];
               rsp_in.group_end = job_ff.end_of_burst;
               rsp_in.last      = 1'b1;
            end
         end
         slwcg_pkg::OP_ROTATE: begin
            if (step_ff == S_FIRST) begin
               rsp_in.out_byte = slwcg_pkg::CMD_MADCTL;
            end else begin
               rsp_in.out_byte  = job_ff.madctl;
               rsp_in.is_data   = 1'b1;
               rsp_in.group_end = 1'b1;
               rsp_in.last      = 1'b1;
            end
         end
         default: begin
            case (step_ff)
               S_ROW_CMD: rsp_in.out_byte = slwcg_pkg::CMD_RASET;
               S_ROW_HI0, S_ROW_HI1, S_COL_HI0, S_COL_HI1: begin
                  rsp_in.is_data = 1'b1;
               end
               S_ROW_START: begin
                  rsp_in.out_byte = job_ff.row_start;
                  rsp_in.is_data  = 1'b1;
               end
               S_ROW_END: begin
                  rsp_in.out_byte  = job_ff.row_end;
                  rsp_in.is_data   = 1'b1;
                  rsp_in.group_end = 1'b1;
               end
               S_COL_CMD: rsp_in.out_byte = slwcg_pkg::CMD_CASET;
               S_COL_START: begin
                  rsp_in.out_byte = job_ff.col_start;
                  rsp_in.is_data  = 1'b1;
               end
               S_COL_END: begin
                  rsp_in.out_byte  = job_ff.col_end;
                  rsp_in.is_data   = 1'b1;
                  rsp_in.group_end = 1'b1;
               end
               S_RAMWR: begin
                  // set window ends here, put pixel keeps chip select for the colour
                  rsp_in.out_byte  = slwcg_pkg::CMD_RAMWR;
                  rsp_in.group_end = (job_ff.op == slwcg_pkg::OP_SET_WINDOW);
                  rsp_in.last      = (job_ff.op == slwcg_pkg::OP_SET_WINDOW);
               end
               S_COLOR_LO: begin
                  rsp_in.out_byte = job_ff.color[7:0];
                  rsp_in.is_data  = 1'b1;
               end
               S_COLOR_HI: begin
                  rsp_in.out_byte  = job_ff.color[15:8];
                  rsp_in.is_data   = 1'b1;
                  rsp_in.group_end = 1'b1;
                  rsp_in.last      = 1'b1;
               end
               default: rsp_in = '0;
            endcase
         end
      endcase
   end

   assign done = active_ff && rsp_in.last;
   assign pop  = !queue_empty && (!active_ff || done);

   always_comb begin
      active_in = active_ff;
      step_in   = step_ff;
      job_in    = job_ff;
      strobe_in = active_ff;
      if (pop) begin
         active_in = 1'b1;
         step_in   = S_FIRST;
         job_in    = queue_data;
      end else if (done) begin
         active_in = 1'b0;
      end else if (active_ff) begin
         step_in = step_ff + 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         step_ff   <= S_FIRST;
         strobe_ff <= 1'b0;
      end else begin
         active_ff <= active_in;
         step_ff   <= step_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

// ----- hw/rtl/slwcg_checker.sv -----
module slwcg_checker (
   input logic               clock,
   input logic               reset,
   input logic               busy,
   input logic               rsp_strobe,
   input slwcg_pkg::rsp_type rsp_data
);

   // nothing comes out in the cycle after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_strobe && !busy)
      else $error("response or busy right after reset");

   // bytes of one request are back to back
   a_no_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_data.last |=> rsp_strobe)
      else $error("gap inside a request's byte stream");

   // only memory-write ends a group as a bare command
   a_cmd_group_end: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_data.is_data && rsp_data.group_end |->
         rsp_data.out_byte == slwcg_pkg::CMD_RAMWR)
      else $error("command byte closes a group");

   // access control command is followed by its final data byte
   a_madctl_data: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_data.is_data && rsp_data.out_byte == slwcg_pkg::CMD_MADCTL |=>
         rsp_strobe && rsp_data.is_data && rsp_data.last && rsp_data.group_end)
      else $error("access control byte not followed by its data");

endmodule

bind spi_lcd_window_command_generator_unit slwcg_checker u_checker (.*);

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps

module tb;
   import slwcg_pkg::*;

   class lcd_byte_checker;
      rsp_type pending_bytes[$];
      int      mismatches;
      int      bytes_checked;

      function new();
         mismatches    = 0;
         bytes_checked = 0;
      endfunction

      function void push_byte(logic [7:0] b, logic is_data, logic group_end, logic last);
         rsp_type e;
         e.out_byte  = b;
         e.is_data   = is_data;
         e.group_end = group_end;
         e.last      = last;
         pending_bytes.push_back(e);
      endfunction

      // command byte, then 00 start 00 end as data, chip select released on the end
      function void push_range(logic [7:0] cmd, logic [7:0] first, logic [7:0] final_pos);
         push_byte(cmd, 1'b0, 1'b0, 1'b0);
         push_byte(8'h00, 1'b1, 1'b0, 1'b0);
         push_byte(first, 1'b1, 1'b0, 1'b0);
         push_byte(8'h00, 1'b1, 1'b0, 1'b0);
         push_byte(final_pos, 1'b1, 1'b1, 1'b0);
      endfunction

      function void note_request(req_type r, logic [1:0] rot);
         logic       swap;
         logic [7:0] x_end;
         logic [7:0] y_end;
         logic [7:0] madctl;
         swap  = (rot == ROT_90) || (rot == ROT_270);
         x_end = r.x + r.width[7:0] - 8'd1;
         y_end = r.y + r.height[7:0] - 8'd1;
         case (r.operation)
            OP_SET_WINDOW: begin
               if (swap) begin
                  push_range(CMD_RASET, r.x, x_end);
                  push_range(CMD_CASET, r.y, y_end);
               end else begin
                  push_range(CMD_RASET, r.y, y_end);
                  push_range(CMD_CASET, r.x, x_end);
               end
               push_byte(CMD_RAMWR, 1'b0, 1'b1, 1'b1);
            end
            OP_PUT_PIXEL: begin
               // row and column arguments are crossed relative to set window
               if (swap) begin
                  push_range(CMD_RASET, r.y, r.y);
                  push_range(CMD_CASET, r.x, r.x);
               end else begin
                  push_range(CMD_RASET, r.x, r.x);
                  push_range(CMD_CASET, r.y, r.y);
               end
               push_byte(CMD_RAMWR, 1'b0, 1'b0, 1'b0);
               push_byte(r.color[7:0], 1'b1, 1'b0, 1'b0);
               push_byte(r.color[15:8], 1'b1, 1'b1, 1'b1);
            end
            OP_STREAM_PIXEL: begin
               push_byte(r.color[7:0], 1'b1, 1'b0, 1'b0);
               push_byte(r.color[15:8], 1'b1, r.end_of_burst, 1'b1);
            end
            OP_ROTATE: begin
               case (rot)
                  ROT_0:   madctl = MADCTL_ROT_0;
                  ROT_90:  madctl = MADCTL_ROT_90;
                  ROT_180: madctl = MADCTL_ROT_180;
                  default: madctl = MADCTL_ROT_270;
               endcase
               push_byte(CMD_MADCTL, 1'b0, 1'b0, 1'b0);
               push_byte(madctl, 1'b1, 1'b1, 1'b1);
            end
         endcase
      endfunction

      function void check_byte(rsp_type got);
         rsp_type want;
         if (pending_bytes.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: unexpected byte %h data %b gend %b last %b", $time,
                        got.out_byte, got.is_data, got.group_end, got.last);
            return;
         end
         want = pending_bytes.pop_front();
         bytes_checked++;
         if (got.out_byte !== want.out_byte || got.is_data !== want.is_data ||
             got.group_end !== want.group_end || got.last !== want.last) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: byte %0d expected %h/%b/%b/%b got %h/%b/%b/%b", $time,
                        bytes_checked, want.out_byte, want.is_data, want.group_end,
                        want.last, got.out_byte, got.is_data, got.group_end, got.last);
         end
      endfunction

      function int pending();
         return pending_bytes.size();
      endfunction

      function void flush_check();
         if (pending_bytes.size() != 0) begin
            mismatches += pending_bytes.size();
            $display("%0t: %0d expected bytes never arrived", $time, pending_bytes.size());
         end
      endfunction
   endclass

   localparam int STALL_LIMIT = 2000;

   logic       clock = 1'b0;
   logic       reset;
   logic       start;
   logic       busy;
   req_type    req_data;
   logic       rsp_strobe;
   rsp_type    rsp_data;
   logic       csr_valid;
   logic       csr_ready;
   logic [1:0] csr_wdata;

   lcd_byte_checker checker_sb;
   logic [1:0]      rotation_setting;
   int              requests_taken = 0;
   int              stall_cycles = 0;
   bit              sender_gaps = 1'b0;

   spi_lcd_window_command_generator_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // requests and bytes are both taken from pre-edge values, so order within the step is moot
   always @(posedge clock) begin
      if (reset) begin
         rotation_setting <= ROT_0;
      end else begin
         if (start && !busy) begin
            checker_sb.note_request(req_data, rotation_setting);
            requests_taken++;
         end
         if (rsp_strobe)
            checker_sb.check_byte(rsp_data);
         if (csr_valid && csr_ready)
            rotation_setting <= csr_wdata;
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe || (csr_valid && csr_ready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
         $display("end of test: mismatches");
         $finish;
      end
   end

   function automatic req_type make_req(logic [1:0] op, logic [7:0] x, logic [7:0] y,
                                        logic [8:0] w, logic [8:0] h, logic [15:0] color,
                                        logic eob);
      req_type r;
      r.operation    = op;
      r.x            = x;
      r.y            = y;
      r.width        = w;
      r.height       = h;
      r.color        = color;
      r.end_of_burst = eob;
      return r;
   endfunction

   function automatic logic [8:0] random_extent();
      case ($urandom_range(0, 7))
         0:       return 9'd0;
         1:       return 9'd256;
         2:       return 9'd1;
         default: return 9'($urandom_range(1, 255));
      endcase
   endfunction

   function automatic req_type random_req(logic [1:0] op);
      return make_req(op, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                      random_extent(), random_extent(), 16'($urandom_range(0, 65535)),
                      1'($urandom_range(0, 1)));
   endfunction

   task automatic send_request(input req_type r);
      if (sender_gaps && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_data <= r;
      start    <= 1'b1;
      do @(posedge clock); while (busy);
   endtask

   task automatic wait_for_drain();
      start <= 1'b0;
      do @(posedge clock); while (checker_sb.pending() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_rotation(input logic [1:0] rot);
      wait_for_drain();
      csr_wdata <= rot;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   initial begin
      logic [1:0] rot_order[4];
      req_type    r;
      int         phase_items;
      int         burst_len;

      checker_sb = new();
      rot_order  = '{ROT_90, ROT_180, ROT_270, ROT_0};
      reset     <= 1'b1;
      start     <= 1'b0;
      req_data  <= '0;
      csr_valid <= 1'b0;
      csr_wdata <= ROT_0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // reset rotation first, then extremes of every field
      send_request(make_req(OP_SET_WINDOW, 8'd0, 8'd0, 9'd256, 9'd256, 16'h0000, 1'b0));
      send_request(make_req(OP_SET_WINDOW, 8'd255, 8'd255, 9'd0, 9'd0, 16'hFFFF, 1'b1));
      send_request(make_req(OP_SET_WINDOW, 8'd17, 8'd200, 9'd1, 9'd100, 16'h0000, 1'b0));
      send_request(make_req(OP_PUT_PIXEL, 8'd0, 8'd255, 9'd0, 9'd0, 16'h0000, 1'b0));
      send_request(make_req(OP_PUT_PIXEL, 8'd255, 8'd0, 9'd511, 9'd511, 16'hFFFF, 1'b1));
      send_request(make_req(OP_STREAM_PIXEL, 8'd0, 8'd0, 9'd0, 9'd0, 16'h1234, 1'b0));
      send_request(make_req(OP_STREAM_PIXEL, 8'd255, 8'd255, 9'd256, 9'd256, 16'hFFFF, 1'b1));
      send_request(make_req(OP_STREAM_PIXEL, 8'd0, 8'd0, 9'd0, 9'd0, 16'h0000, 1'b1));
      send_request(make_req(OP_ROTATE, 8'd0, 8'd0, 9'd0, 9'd0, 16'h0000, 1'b0));
      foreach (rot_order[i]) begin
         write_rotation(rot_order[i]);
         send_request(make_req(OP_ROTATE, 8'd0, 8'd0, 9'd0, 9'd0, 16'h0000, 1'b0));
         send_request(make_req(OP_SET_WINDOW, 8'd3, 8'd250, 9'd10, 9'd256, 16'h0000, 1'b0));
         send_request(make_req(OP_PUT_PIXEL, 8'd5, 8'd200, 9'd0, 9'd0, 16'hA55A, 1'b0));
      end

      for (int phase = 0; phase < 6; phase++) begin
         write_rotation(phase < 4 ? rot_order[phase] : 2'($urandom_range(0, 3)));
         phase_items = 0;
         while (phase_items < 42) begin
            // gaps early in each phase, a clean stretch after, none in the last phase
            sender_gaps = (phase < 5) && (phase_items < 28);
            case ($urandom_range(0, 9))
               0, 1, 2, 3, 4, 5: begin
                  send_request(random_req(OP_SET_WINDOW));
                  burst_len = $urandom_range(1, 8);
                  for (int i = 0; i < burst_len; i++) begin
                     r = random_req(OP_STREAM_PIXEL);
                     r.end_of_burst = (i == burst_len - 1);
                     send_request(r);
                  end
                  phase_items += burst_len + 1;
               end
               6, 7: begin
                  send_request(random_req(OP_PUT_PIXEL));
                  phase_items++;
               end
               8: begin
                  send_request(random_req(OP_ROTATE));
                  phase_items++;
               end
               default: begin
                  send_request(random_req(2'($urandom_range(0, 3))));
                  phase_items++;
               end
            endcase
         end
      end

      wait_for_drain();
      repeat (16) @(posedge clock);
      checker_sb.flush_check();
      $display("covered %0d requests over all four rotations, %0d bytes compared",
               requests_taken, checker_sb.bytes_checked);
      $display("window extents 0 to 256, colour and burst-end extremes, with and without gaps");
      if (checker_sb.mismatches == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
